[design/ektc_pkg.sv]
// Shared types and constants for the key threshold calibrator.
package ektc_pkg;

  // Default number of matrix rows with a stored baseline
  localparam int ROW_COUNT_DEF = 8;

  // Field widths
  localparam int OpW    = 2;
  localparam int RowW   = 3;
  localparam int DataW  = 8;
  localparam int ClassW = 2;
  localparam int CfgIdxW = 2;

  // Item opcodes
  typedef enum logic [OpW-1:0] {
    OP_BEGIN    = 2'd0,
    OP_SAMPLE   = 2'd1,
    OP_FINISH   = 2'd2,
    OP_CLASSIFY = 2'd3
  } op_e;

  // Key classification codes
  typedef enum logic [ClassW-1:0] {
    CLS_RELEASED = 2'd0,
    CLS_BETWEEN  = 2'd1,
    CLS_PRESSED  = 2'd2
  } key_class_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_VALID_MIN      = 2'd0,
    CFG_VALID_MAX      = 2'd1,
    CFG_ACTIVE_OFFSET  = 2'd2,
    CFG_RELEASE_OFFSET = 2'd3
  } cfg_idx_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_ADD
  } state_e;

  // Input transaction held while it is worked on
  typedef struct packed {
    op_e              opcode;
    logic [RowW-1:0]  row;
    logic [DataW-1:0] sample;
    logic [DataW-1:0] row_extra;
  } item_t;

  // Reset values of the configuration registers
  localparam logic [DataW-1:0] VALID_MIN_RST = 8'h00;
  localparam logic [DataW-1:0] VALID_MAX_RST = 8'hFF;

endpackage

[design/ektc_if.sv]
// Valid/ready channel interfaces for input and result transactions.
interface ektc_in_if;
  import ektc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [RowW-1:0]  row;
  logic [DataW-1:0] sample;
  logic [DataW-1:0] row_extra;

  modport source (output valid, opcode, row, sample, row_extra, input ready);
  modport sink   (input valid, opcode, row, sample, row_extra, output ready);
endinterface

interface ektc_out_if;
  import ektc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ClassW-1:0] key_class;
  logic [DataW-1:0]  threshold;

  modport source (output valid, key_class, threshold, input ready);
  modport sink   (input valid, key_class, threshold, output ready);
endinterface

[design/ektc_row_mem.sv]
// Row baseline memory: one write port, one registered read port, per-row valid bits.
module ektc_row_mem #(
  parameter int ROW_COUNT = ektc_pkg::ROW_COUNT_DEF,
  localparam int AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [ektc_pkg::DataW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [ektc_pkg::DataW-1:0] rdata_o
);
  import ektc_pkg::*;

  logic [DataW-1:0]     mem [ROW_COUNT];
  logic [ROW_COUNT-1:0] valid_q;
  logic [DataW-1:0]     rdata_q;
  logic                 rvalid_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Written flags; an unwritten row reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[design/ektc_classify.sv]
// Threshold and hysteresis classification of one sample.
module ektc_classify (
  input  logic [ektc_pkg::DataW-1:0]  base_i,
  input  logic [ektc_pkg::DataW-1:0]  row_extra_i,
  input  logic [ektc_pkg::DataW-1:0]  sample_i,
  input  logic [ektc_pkg::DataW-1:0]  release_offset_i,
  output logic [ektc_pkg::DataW-1:0]  threshold_o,
  output logic [ektc_pkg::ClassW-1:0] key_class_o
);
  import ektc_pkg::*;

  logic [DataW-1:0]        thr;
  logic signed [DataW+1:0] low_lvl;
  logic signed [DataW+1:0] smp_s;
  key_class_e              cls;

  // Threshold wraps at 8 bits; release level may go negative
  assign thr     = base_i + row_extra_i;
  assign low_lvl = $signed({2'b00, thr}) - $signed({2'b00, release_offset_i});
  assign smp_s   = $signed({2'b00, sample_i});

  always_comb begin
    priority if (smp_s <= low_lvl) begin
      cls = CLS_RELEASED;
    end else if (sample_i >= thr) begin
      cls = CLS_PRESSED;
    end else begin
      cls = CLS_BETWEEN;
    end
  end

  assign threshold_o = thr;
  assign key_class_o = cls;

endmodule

[design/ec_key_threshold_calibrator_core.sv]
// Capacitive key threshold calibrator: per-row baseline store and classifier.
//
// Input channel in_i carries opcode, row, sample and row_extra; each accepted
// transaction yields exactly one result on out_o: key class and the threshold
// built from the row baseline as it stood before the transaction's own update.
// The baselines sit in a synchronous memory with a registered read port.
// A transaction's row is read in its accept cycle and its result is registered
// at the end of ST_EXEC, which then raises out_o.valid.
// Classify and sample transactions take a memory read, then a compute step in
// which a sample may also be written back. Begin calibration walks every row,
// and finish calibration reads and writes every row in an overlapped sweep.
// Reset clears all baselines to zero through per-row valid bits, so no
// clearing sweep is needed, and returns the control and configuration registers to their reset values.
// A stalled result waits in the output register; a new transaction is taken
// only when that register is empty or being drained in the same cycle.
// Configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i take effect at
// once and are meant to be issued while the block is idle.
module ec_key_threshold_calibrator_core #(
  parameter int ROW_COUNT = ektc_pkg::ROW_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ektc_in_if.sink                     in_i,
  ektc_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [ektc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ektc_pkg::DataW-1:0]   cfg_data_i
);
  import ektc_pkg::*;

  localparam int AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CW = $clog2(ROW_COUNT + 1);

  // Configuration registers
  logic [DataW-1:0] valid_min_q, valid_max_q, active_offset_q, release_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_min_q      <= VALID_MIN_RST;
      valid_max_q      <= VALID_MAX_RST;
      active_offset_q  <= '0;
      release_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VALID_MIN:      valid_min_q      <= cfg_data_i;
        CFG_VALID_MAX:      valid_max_q      <= cfg_data_i;
        CFG_ACTIVE_OFFSET:  active_offset_q  <= cfg_data_i;
        CFG_RELEASE_OFFSET: release_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  item_t          item_q;
  logic           out_valid_q, out_valid_d;
  logic [ClassW-1:0] out_class_q;
  logic [DataW-1:0]  out_thr_q;

  // Memory port signals
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [DataW-1:0] mem_wdata, mem_rdata;

  // Datapath for the transaction in ST_EXEC
  logic              row_ok;
  logic [DataW-1:0]  base;
  logic [DataW-1:0]  smp_inc;
  logic [DataW-1:0]  avg_sum;
  logic              smp_in_win;
  logic [DataW-1:0]  cls_thr;
  logic [ClassW-1:0] cls_code;
  logic              in_acc, out_free, load_out;
  logic [CW-1:0]     cnt_prev;

  assign row_ok     = 32'(item_q.row) < ROW_COUNT;
  assign base       = row_ok ? mem_rdata : '0;
  assign smp_inc    = item_q.sample + 8'd1;
  assign smp_in_win = (smp_inc >= valid_min_q) && (smp_inc <= valid_max_q);
  assign avg_sum    = base + smp_inc;
  assign cnt_prev   = cnt_q - 1'b1;

  ektc_classify u_classify (
    .base_i          (base),
    .row_extra_i     (item_q.row_extra),
    .sample_i        (item_q.sample),
    .release_offset_i(release_offset_q),
    .threshold_o     (cls_thr),
    .key_class_o     (cls_code)
  );

  ektc_row_mem #(.ROW_COUNT(ROW_COUNT)) u_row_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output slot is free when empty or draining this cycle
  assign out_free = !out_valid_q || out_o.ready;
  assign in_acc   = in_i.valid && in_i.ready;

  // Next state, memory control and handshake
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    in_i.ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = out_free;
        mem_re     = in_i.valid && out_free;
        mem_raddr  = AW'(in_i.row);
        if (in_i.valid && out_free) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        load_out = 1'b1;
        cnt_d    = '0;
        unique case (item_q.opcode)
          OP_BEGIN:  state_d = ST_FILL;
          OP_FINISH: state_d = ST_ADD;
          OP_SAMPLE: begin
            mem_we    = row_ok && smp_in_win;
            mem_waddr = AW'(item_q.row);
            mem_wdata = avg_sum >> 1;
            state_d   = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        // One row per cycle gets valid_min
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = valid_min_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CW'(ROW_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ADD: begin
        // Read row cnt while writing back row cnt-1 plus the offset
        mem_re    = cnt_q != CW'(ROW_COUNT);
        mem_raddr = cnt_q[AW-1:0];
        mem_we    = cnt_q != '0;
        mem_waddr = cnt_prev[AW-1:0];
        mem_wdata = mem_rdata + active_offset_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CW'(ROW_COUNT)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.opcode    <= op_e'(in_i.opcode);
      item_q.row       <= in_i.row;
      item_q.sample    <= in_i.sample;
      item_q.row_extra <= in_i.row_extra;
    end
    if (load_out) begin
      out_class_q <= cls_code;
      out_thr_q   <= cls_thr;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.key_class = out_class_q;
  assign out_o.threshold = out_thr_q;

endmodule

[design/ektc_checker.sv]
// Port-level assertions for the calibrator core, with the bind that attaches them.
module ektc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [ektc_pkg::DataW-1:0] out_threshold_i
);

  // One transaction in flight: no accept in the cycle right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

  // Every accepted transaction shows its result on out_valid_i
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> ##2 out_valid_i)
    else $error("result missing after accepted transaction");

  // Ready only when the result slot can take a new result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> (!out_valid_i || out_ready_i))
    else $error("input ready while result slot is blocked");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_threshold_i)))
    else $error("stalled result changed");

endmodule

bind ec_key_threshold_calibrator_core ektc_checker u_ektc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_threshold_i(out_o.threshold)
);
